>>> src/rned_pkg.sv
package rned_pkg;

  localparam int CH_W    = 8;
  localparam int THR_W   = 8;
  localparam int WREG_W  = 11;
  localparam int HREG_W  = 13;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [THR_W-1:0]  THR_RESET    = 8'd30;
  localparam logic [WREG_W-1:0] WIDTH_RESET  = 11'd1024;
  localparam logic [HREG_W-1:0] HEIGHT_RESET = 13'd1024;

  // register index, taken from paddr[3:2]
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_WIDTH     = 2'd1;
  localparam logic [1:0] REG_HEIGHT    = 2'd2;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } pixel_t;

endpackage

>>> src/rned_ifs.sv
interface rned_pix_if import rned_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rned_res_if import rned_pkg::*; ();
  logic valid;
  logic ready;
  logic edge_res;
  logic row_end;
  logic frame_end;

  modport source (output valid, output edge_res, output row_end, output frame_end,
                  input ready);
  modport sink   (input valid, input edge_res, input row_end, input frame_end,
                  output ready);
endinterface

>>> src/rgb_neighbor_edge_detect_top.sv
// Channel   Dir  Handshake      Beat contents
// pix_i     in   valid/ready    red, green, blue (8 bit unsigned each)
// res_o     out  valid/ready    edge_res, row_end, frame_end
// APB       in   psel/penable   threshold @0x0, image_width @0x4, image_height @0x8
//
// One pixel per clock sustained while the sink takes results; each pixel goes from input beat to
// result beat by the line store read, then difference and compare into the output register.
// The line store is a single-port-style memory read and written at the same column
// in the accept cycle; the read returns the previous row, so no forwarding is needed.
// Reset sets counters, valid flags and config registers; data registers and line store are not reset.
// A stalled output holds the pipeline; the input is refused only when both the
// compare stage and the output register are full and the sink is not taking.
module rgb_neighbor_edge_detect_top import rned_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  rned_pix_if.sink           pix_i,
  rned_res_if.source         res_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  // ---------------- configuration registers ----------------
  logic [THR_W-1:0]  threshold_q;
  logic [WREG_W-1:0] width_q;
  logic [HREG_W-1:0] height_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THR_RESET;
      width_q     <= WIDTH_RESET;
      height_q    <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_THRESHOLD: threshold_q <= pwdata[THR_W-1:0];
        REG_WIDTH:     width_q     <= pwdata[WREG_W-1:0];
        REG_HEIGHT:    height_q    <= pwdata[HREG_W-1:0];
        default:       ;  // drop writes beyond the register list
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_THRESHOLD: prdata = PDATA_W'(threshold_q);
      REG_WIDTH:     prdata = PDATA_W'(width_q);
      REG_HEIGHT:    prdata = PDATA_W'(height_q);
      default:       prdata = '0;
    endcase
  end

  // Saturate the frame size: zero acts as one, oversize acts as the maximum.
  logic [31:0] width_ext, height_ext, last_col_full, last_row_full;
  logic [COL_W-1:0] last_col;
  logic [ROW_W-1:0] last_row;

  always_comb begin
    width_ext  = 32'(width_q);
    height_ext = 32'(height_q);
    if (width_ext == 32'd0)                 last_col_full = 32'd0;
    else if (width_ext > 32'(MAX_WIDTH))    last_col_full = 32'(MAX_WIDTH - 1);
    else                                    last_col_full = width_ext - 32'd1;
    if (height_ext == 32'd0)                last_row_full = 32'd0;
    else if (height_ext > 32'(MAX_HEIGHT))  last_row_full = 32'(MAX_HEIGHT - 1);
    else                                    last_row_full = height_ext - 32'd1;
  end

  assign last_col = last_col_full[COL_W-1:0];
  assign last_row = last_row_full[ROW_W-1:0];

  // ---------------- pipeline control ----------------
  logic   s1_valid_q;
  logic   out_valid_q;
  logic   advance;
  logic   in_acc;
  pixel_t pix;

  assign advance     = !out_valid_q || res_o.ready;
  assign pix_i.ready = !s1_valid_q || advance;
  assign in_acc      = pix_i.valid && pix_i.ready;
  assign pix         = '{blue: pix_i.blue, green: pix_i.green, red: pix_i.red};

  // ---------------- stage 0: counters, line store access ----------------
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             rend, fend;

  assign rend = col_q >= last_col;
  assign fend = rend && (row_q >= last_row);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (rend) begin
      col_d = '0;
      row_d = fend ? '0 : row_q + ROW_W'(1);
    end else begin
      col_d = col_q + COL_W'(1);
    end
  end

  logic [$bits(pixel_t)-1:0] line_mem [MAX_WIDTH];
  pixel_t                    up_q;

  // Read the previous row and overwrite it with the current pixel in one access.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      line_mem[col_q] <= pix;
      up_q            <= line_mem[col_q];
    end
  end

  pixel_t left_q;
  pixel_t s1_pix_q, s1_left_q;
  logic   s1_has_up_q, s1_has_left_q, s1_rend_q, s1_fend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (in_acc)       s1_valid_q <= 1'b1;
      else if (advance) s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      left_q        <= pix;
      s1_pix_q      <= pix;
      s1_left_q     <= left_q;
      s1_has_up_q   <= row_q != '0;
      s1_has_left_q <= col_q != '0;
      s1_rend_q     <= rend;
      s1_fend_q     <= fend;
    end
  end

  // ---------------- stage 1: compare against neighbours ----------------
  function automatic logic differs(pixel_t a, pixel_t b, logic [THR_W-1:0] thr);
    logic [CH_W-1:0] dr, dg, db;
    dr = (a.red   > b.red)   ? a.red   - b.red   : b.red   - a.red;
    dg = (a.green > b.green) ? a.green - b.green : b.green - a.green;
    db = (a.blue  > b.blue)  ? a.blue  - b.blue  : b.blue  - a.blue;
    return (dr > thr) || (dg > thr) || (db > thr);
  endfunction

  logic edge_d;

  assign edge_d = (s1_has_up_q   && differs(up_q,      s1_pix_q, threshold_q)) ||
                  (s1_has_left_q && differs(s1_left_q, s1_pix_q, threshold_q));

  logic edge_q, row_end_q, frame_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      edge_q      <= edge_d;
      row_end_q   <= s1_rend_q;
      frame_end_q <= s1_fend_q;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.edge_res  = edge_q;
  assign res_o.row_end   = row_end_q;
  assign res_o.frame_end = frame_end_q;

  // ---------------- assertions ----------------
  a_first_pixel_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_has_up_q && !s1_has_left_q |-> !edge_d)
    else $error("first pixel of frame marked as edge");

  a_frame_end_on_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && frame_end_q |-> row_end_q)
    else $error("frame end without row end");

  a_stall_holds_stage1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !advance |=> s1_valid_q && $stable(s1_pix_q) && $stable(up_q))
    else $error("compare stage lost its pixel during a stall");

  a_empty_takes_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> pix_i.ready)
    else $error("input refused while output register empty");

  a_row_end_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && rend |=> col_q == '0)
    else $error("column counter did not wrap at row end");

endmodule
